### hdl/cartridge_bank_mapper_unit_assert.svh
`ifndef CARTRIDGE_BANK_MAPPER_UNIT_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CBM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cartridge mapper check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CBM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cartridge mapper check failed");

`endif

### hdl/cbm_pkg.sv
package cbm_pkg;

    localparam int PAGE_BITS  = 6;
    localparam int ADDR_W     = 20;
    localparam int OFFSET_W   = 14;
    localparam int ROM_WIDE_W = ADDR_W + PAGE_BITS;

    localparam logic [15:0] ADDR_BANK_CTRL  = 16'hFFFC;
    localparam logic [15:0] ADDR_SLOT0_REG  = 16'hFFFD;
    localparam logic [15:0] ADDR_SLOT1_REG  = 16'hFFFE;
    localparam logic [15:0] ADDR_SLOT2_REG  = 16'hFFFF;
    localparam logic [15:0] ADDR_ALT_SLOT0  = 16'h0000;
    localparam logic [15:0] ADDR_ALT_SLOT1  = 16'h4000;
    localparam logic [15:0] ADDR_ALT_SLOT2  = 16'h8000;
    localparam logic [15:0] ADDR_FIXED_LIM  = 16'h0400;
    localparam logic [15:0] ADDR_SLOT2_BASE = 16'h8000;
    localparam logic [15:0] ADDR_SYSRAM     = 16'hC000;

    localparam logic [7:0] MASK_PAGE_SMALL = 8'h1F;
    localparam logic [7:0] MASK_PAGE_LARGE = 8'h3F;

    localparam logic CFG_ALT_MODE  = 1'b0;
    localparam logic CFG_LARGE_ROM = 1'b1;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        TARGET_NONE     = 2'd0,
        TARGET_ROM      = 2'd1,
        TARGET_SYS_RAM  = 2'd2,
        TARGET_CART_RAM = 2'd3
    } cbm_target_t;

    typedef struct packed {
        logic alternate_mapper_mode;
        logic large_rom_mode;
    } cbm_cfg_t;

    typedef struct packed {
        logic [PAGE_BITS-1:0] slot0_page;
        logic [PAGE_BITS-1:0] slot1_page;
        logic [PAGE_BITS-1:0] slot2_page;
        logic                 ram_mapped;
        logic                 ram_bank_select;
        logic                 control_ram_bit;
    } cbm_state_t;

    typedef struct packed {
        cbm_target_t       target;
        logic [ADDR_W-1:0] mem_address;
        logic              write_enable;
        logic [7:0]        data_out;
    } cbm_result_t;

    function automatic logic [ADDR_W-1:0] rom_at(input logic [PAGE_BITS-1:0] page,
                                                 input logic [OFFSET_W-1:0]  offset);
        logic [ROM_WIDE_W-1:0] wide;
        wide = ROM_WIDE_W'({page, offset});
        return wide[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cart_ram_at(input logic                bank,
                                                      input logic [OFFSET_W-1:0] offset);
        return ADDR_W'({bank, offset});
    endfunction

endpackage

### hdl/cbm_xlate.sv
module cbm_xlate
    import cbm_pkg::*;
(
    input  cbm_cfg_t    cfg,
    input  cbm_state_t  state,
    input  logic        command,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    output cbm_result_t result,
    output cbm_state_t  state_next
);

    logic [OFFSET_W-1:0]  offset;
    logic [PAGE_BITS-1:0] alt_page;
    logic [PAGE_BITS-1:0] std_page;
    logic [7:0]           std_mask;

    assign offset   = address[OFFSET_W-1:0];
    assign alt_page = PAGE_BITS'(write_data & MASK_PAGE_SMALL);
    assign std_mask = cfg.large_rom_mode ? MASK_PAGE_LARGE : MASK_PAGE_SMALL;
    assign std_page = PAGE_BITS'(write_data & std_mask);

    always_comb
    begin
        result     = '{target: TARGET_NONE, mem_address: '0, write_enable: 1'b0,
                       data_out: 8'h00};
        state_next = state;

        if (command == CMD_READ)
        begin
            if (address >= ADDR_SYSRAM)
            begin
                result.target      = TARGET_SYS_RAM;
                result.mem_address = ADDR_W'(address[12:0]);
            end
            else if (address >= ADDR_SLOT2_BASE)
            begin
                if (state.ram_mapped)
                begin
                    result.target      = TARGET_CART_RAM;
                    result.mem_address = cart_ram_at(state.ram_bank_select, offset);
                end
                else
                begin
                    result.target      = TARGET_ROM;
                    result.mem_address = rom_at(state.slot2_page, offset);
                end
            end
            else if (address >= ADDR_ALT_SLOT1)
            begin
                result.target      = TARGET_ROM;
                result.mem_address = rom_at(state.slot1_page, offset);
            end
            else
            begin
                result.target = TARGET_ROM;
                // first 1 KB is pinned to the start of rom in standard mode
                if (!cfg.alternate_mapper_mode && address < ADDR_FIXED_LIM)
                    result.mem_address = ADDR_W'(address);
                else
                    result.mem_address = rom_at(state.slot0_page, offset);
            end
        end
        else
        begin
            result.data_out = write_data;

            if (cfg.alternate_mapper_mode)
            begin
                if (address == ADDR_ALT_SLOT0)
                    state_next.slot0_page = alt_page;
                else if (address == ADDR_ALT_SLOT1)
                    state_next.slot1_page = alt_page;
                else if (address == ADDR_ALT_SLOT2)
                    state_next.slot2_page = alt_page;
            end

            if (address >= ADDR_SYSRAM)
            begin
                result.target       = TARGET_SYS_RAM;
                result.mem_address  = ADDR_W'(address[12:0]);
                result.write_enable = 1'b1;

                if (address == ADDR_BANK_CTRL)
                    state_next.control_ram_bit = write_data[3];

                if (!cfg.alternate_mapper_mode)
                begin
                    if (address == ADDR_BANK_CTRL)
                    begin
                        state_next.ram_mapped      = write_data[3];
                        state_next.ram_bank_select = write_data[2];
                    end
                    else if (address == ADDR_SLOT0_REG)
                        state_next.slot0_page = std_page;
                    else if (address == ADDR_SLOT1_REG)
                        state_next.slot1_page = std_page;
                    else if (address == ADDR_SLOT2_REG && !state.control_ram_bit)
                        state_next.slot2_page = std_page;
                end
            end
            else if (address >= ADDR_SLOT2_BASE && state.ram_mapped)
            begin
                result.target       = TARGET_CART_RAM;
                result.mem_address  = cart_ram_at(state.ram_bank_select, offset);
                result.write_enable = 1'b1;
            end
        end
    end

endmodule

### hdl/cartridge_bank_mapper_unit.sv
// Bus address translator for a bank-switched cartridge: every accepted CPU access (read or
// write, 16-bit address, data byte) yields one result naming the target memory (rom,
// 8 KB system ram mirrored every 8 KB, cartridge ram, or none for a dropped write), the
// physical byte address and a write enable. Paging writes update the slot registers and
// take effect for the very next access. One access is taken every cycle unless the result
// side stalls; each result passes through the input register, then the result register,
// with the slot register lookup and address decode done between those two registers. The
// user must write mode bits through the cfg port only while no access is in flight; the
// block itself does not enforce this.
`include "cartridge_bank_mapper_unit_assert.svh"

module cartridge_bank_mapper_unit
    import cbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
    input  logic        s_tuser,   // command[0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // mem_address[19:0], write_enable[20], data_out[28:21]
    output logic [1:0]  m_tuser    // target[1:0]
);

    cbm_cfg_t    cfg_reg;
    cbm_state_t  state_reg;
    cbm_state_t  state_next;
    cbm_result_t result_next;
    cbm_result_t result_reg;

    logic        in_valid_reg;
    logic        in_command_reg;
    logic [15:0] in_address_reg;
    logic [7:0]  in_data_reg;
    logic        out_valid_reg;

    logic        in_accept;
    logic        advance;

    assign cfg_ready = 1'b1;

    // item in the input register moves on when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    cbm_xlate u_xlate (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .command    (in_command_reg),
        .address    (in_address_reg),
        .write_data (in_data_reg),
        .result     (result_next),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            state_reg     <= '{slot0_page: PAGE_BITS'(0), slot1_page: PAGE_BITS'(1),
                               slot2_page: PAGE_BITS'(2), ram_mapped: 1'b0,
                               ram_bank_select: 1'b0, control_ram_bit: 1'b0};
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_ALT_MODE:  cfg_reg.alternate_mapper_mode <= cfg_data;
                    CFG_LARGE_ROM: cfg_reg.large_rom_mode        <= cfg_data;
                endcase
            end

            if (advance)
                state_reg <= state_next;

            if (s_tready)
                in_valid_reg <= s_tvalid;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_command_reg <= s_tuser;
            in_address_reg <= s_tdata[15:0];
            in_data_reg    <= s_tdata[23:16];
        end
        if (advance)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.target;
    assign m_tdata  = {3'b000, result_reg.data_out, result_reg.write_enable,
                       result_reg.mem_address};

    `CBM_ASSERT_IMP(a_we_has_target,
        m_tvalid && result_reg.write_enable, result_reg.target != TARGET_NONE)
    `CBM_ASSERT_IMP(a_dropped_is_quiet,
        m_tvalid && result_reg.target == TARGET_NONE,
        result_reg.mem_address == '0 && !result_reg.write_enable)
    `CBM_ASSERT_IMP(a_sysram_mirror,
        m_tvalid && result_reg.target == TARGET_SYS_RAM, result_reg.mem_address[19:13] == '0)
    `CBM_ASSERT_NXT(a_pending_item_held,
        in_valid_reg && !advance, in_valid_reg && $stable(in_address_reg))

endmodule

### verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    localparam int          TIMEOUT_NS = 2_000_000;
    localparam logic [15:0] SLOT1_BASE = 16'h4000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic        cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;    // address[15:0], write_data[23:16]
    logic        s_tuser   = 1'b0;  // command[0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;           // mem_address[19:0], write_enable[20], data_out[28:21]
    logic [1:0]  m_tuser;           // target[1:0]

    // mapper state as the testbench sees it
    logic                 alt_mode      = 1'b0;
    logic                 big_rom       = 1'b0;
    logic [PAGE_BITS-1:0] slot_page [3] = '{PAGE_BITS'(0), PAGE_BITS'(1), PAGE_BITS'(2)};
    logic                 cart_ram_on   = 1'b0;
    logic                 cart_ram_bank = 1'b0;
    logic                 ctrl_latch    = 1'b0;

    cbm_result_t pending_results [$];
    int          errors         = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    logic [15:0] boundary_addrs [7] = '{16'h0000, 16'h03FF, 16'h0400, 16'h4000,
                                        16'h8000, 16'hC000, 16'hFFFC};

    cartridge_bank_mapper_unit dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("** cartridge_bank_mapper_unit: FAILED **");
        $finish;
    end

    // computes the translation of one access and applies its paging side effects
    function automatic cbm_result_t translate_access(input logic        cmd,
                                                     input logic [15:0] addr,
                                                     input logic [7:0]  data);
        cbm_result_t          r;
        logic [PAGE_BITS-1:0] pg;
        r.target       = TARGET_NONE;
        r.mem_address  = '0;
        r.write_enable = 1'b0;
        r.data_out     = 8'h00;
        if (cmd == CMD_READ)
        begin
            if (addr >= ADDR_SYSRAM)
            begin
                r.target      = TARGET_SYS_RAM;
                r.mem_address = ADDR_W'(addr[12:0]);
            end
            else if (addr >= ADDR_SLOT2_BASE)
            begin
                if (cart_ram_on)
                begin
                    r.target      = TARGET_CART_RAM;
                    r.mem_address = ADDR_W'({cart_ram_bank, addr[13:0]});
                end
                else
                begin
                    r.target      = TARGET_ROM;
                    r.mem_address = ADDR_W'({slot_page[2], addr[13:0]});
                end
            end
            else if (addr >= SLOT1_BASE)
            begin
                r.target      = TARGET_ROM;
                r.mem_address = ADDR_W'({slot_page[1], addr[13:0]});
            end
            else
            begin
                r.target = TARGET_ROM;
                // first 1 KB is pinned to rom page 0 in standard mode
                if (!alt_mode && addr < ADDR_FIXED_LIM)
                    r.mem_address = ADDR_W'(addr);
                else
                    r.mem_address = ADDR_W'({slot_page[0], addr[13:0]});
            end
            return r;
        end

        r.data_out = data;
        if (alt_mode)
        begin
            pg = PAGE_BITS'(data & MASK_PAGE_SMALL);
            case (addr)
                ADDR_ALT_SLOT0: slot_page[0] = pg;
                ADDR_ALT_SLOT1: slot_page[1] = pg;
                ADDR_ALT_SLOT2: slot_page[2] = pg;
                default: ;
            endcase
        end

        if (addr >= ADDR_SYSRAM)
        begin
            r.target       = TARGET_SYS_RAM;
            r.mem_address  = ADDR_W'(addr[12:0]);
            r.write_enable = 1'b1;
            if (addr == ADDR_BANK_CTRL)
                ctrl_latch = data[3];
            if (addr >= ADDR_BANK_CTRL && !alt_mode)
            begin
                pg = PAGE_BITS'(data & (big_rom ? MASK_PAGE_LARGE : MASK_PAGE_SMALL));
                case (addr)
                    ADDR_BANK_CTRL:
                    begin
                        cart_ram_on   = data[3];
                        cart_ram_bank = data[2];
                    end
                    ADDR_SLOT0_REG: slot_page[0] = pg;
                    ADDR_SLOT1_REG: slot_page[1] = pg;
                    default:
                        if (!ctrl_latch)
                            slot_page[2] = pg;
                endcase
            end
        end
        else if (addr >= ADDR_SLOT2_BASE && cart_ram_on)
        begin
            r.target       = TARGET_CART_RAM;
            r.mem_address  = ADDR_W'({cart_ram_bank, addr[13:0]});
            r.write_enable = 1'b1;
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        cbm_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got target %0h addr %0h",
                         $time, m_tuser, m_tdata[19:0]);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("target", want.target, m_tuser);
                compare_field("mem_address", want.mem_address, m_tdata[19:0]);
                compare_field("write_enable", want.write_enable, m_tdata[20]);
                compare_field("data_out", want.data_out, m_tdata[28:21]);
            end
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    task automatic send_access(input logic cmd, input logic [15:0] addr,
                               input logic [7:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {data, addr};
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(translate_access(cmd, addr, data));
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stop sending and let every outstanding result drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic idx, input logic val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_ALT_MODE)
            alt_mode = val;
        else
            big_rom = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_access();
        int          pick;
        logic        cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        pick = $urandom_range(99);
        cmd  = 1'($urandom_range(1));
        addr = 16'($urandom);
        data = 8'($urandom);
        if (pick < 30)
        begin
            // paging register write with random content
            cmd = CMD_WRITE;
            if (alt_mode && pick >= 8)
                addr = {2'($urandom_range(2)), 14'h0};
            else
                addr = ADDR_BANK_CTRL + 16'($urandom_range(3));
        end
        else if (pick < 50)
            addr = boundary_addrs[$urandom_range(6)] + 16'($urandom_range(2)) - 16'd1;
        else if (pick < 80)
            cmd = CMD_READ;
        send_access(cmd, addr, data);
    endtask

    task automatic test_reset_mapping();
        send_access(CMD_READ, 16'h0000, 8'hFF);
        send_access(CMD_READ, 16'h03FF, 8'hFF);
        send_access(CMD_READ, 16'h0400, 8'h00);
        send_access(CMD_READ, 16'h3FFF, 8'h00);
        send_access(CMD_READ, 16'h4000, 8'h00);
        send_access(CMD_READ, 16'h8000, 8'h00);
        send_access(CMD_READ, 16'hBFFF, 8'h00);
        send_access(CMD_READ, ADDR_SLOT2_REG, 8'h00);
    endtask

    task automatic test_standard_paging();
        write_mode(CFG_LARGE_ROM, 1'b1);
        send_access(CMD_WRITE, ADDR_SLOT0_REG, 8'hFF);
        send_access(CMD_WRITE, ADDR_SLOT1_REG, 8'hC5);
        send_access(CMD_WRITE, ADDR_SLOT2_REG, 8'h2A);
        send_access(CMD_READ, 16'h0001, 8'h00);
        send_access(CMD_READ, 16'h0400, 8'h00);
        send_access(CMD_READ, 16'h5555, 8'h00);
        send_access(CMD_READ, 16'hA000, 8'h00);
        // writes into rom space and unmapped slot 2 are dropped
        send_access(CMD_WRITE, 16'h1234, 8'hAA);
        send_access(CMD_WRITE, 16'h9000, 8'h55);
        send_access(CMD_WRITE, ADDR_BANK_CTRL, 8'h0C);
        send_access(CMD_WRITE, 16'hBFFF, 8'h81);
        send_access(CMD_READ, 16'h8001, 8'h00);
        // control bit set, so slot 2 page must hold
        send_access(CMD_WRITE, ADDR_SLOT2_REG, 8'h07);
        send_access(CMD_WRITE, ADDR_BANK_CTRL, 8'h00);
        send_access(CMD_READ, 16'h8000, 8'h00);
        write_mode(CFG_LARGE_ROM, 1'b0);
        send_access(CMD_WRITE, ADDR_SLOT2_REG, 8'hFF);
        send_access(CMD_READ, 16'hBFFF, 8'h00);
    endtask

    task automatic test_alternate_paging();
        send_access(CMD_WRITE, ADDR_BANK_CTRL, 8'h08);
        // ram mapping survives the mode change
        write_mode(CFG_ALT_MODE, 1'b1);
        send_access(CMD_READ, 16'h8123, 8'h00);
        send_access(CMD_WRITE, ADDR_ALT_SLOT2, 8'hFF);
        send_access(CMD_WRITE, ADDR_BANK_CTRL, 8'h00);
        send_access(CMD_READ, 16'h9000, 8'h00);
        send_access(CMD_WRITE, ADDR_ALT_SLOT0, 8'hE3);
        send_access(CMD_WRITE, ADDR_ALT_SLOT1, 8'h3F);
        send_access(CMD_READ, 16'h0000, 8'h00);
        send_access(CMD_READ, 16'h7FFF, 8'h00);
        send_access(CMD_WRITE, ADDR_SLOT2_REG, 8'h01);
    endtask

    task automatic test_random_traffic(input int items);
        int src_pct [4]  = '{0, 46, 0, 24};
        int sink_pct [4] = '{0, 0, 46, 24};
        for (int phase = 0; phase < 4; phase++)
        begin
            write_mode(CFG_ALT_MODE, phase[0]);
            write_mode(CFG_LARGE_ROM, phase[1]);
            src_idle_pct   = src_pct[phase];
            sink_stall_pct = sink_pct[phase];
            repeat (items / 4)
                random_access();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_mapping();
        test_standard_paging();
        test_alternate_paging();
        test_random_traffic(400);
        settle();
        if (errors == 0)
            $display("** cartridge_bank_mapper_unit: PASSED **");
        else
            $display("** cartridge_bank_mapper_unit: FAILED **");
        $finish;
    end

endmodule
